// ===== hw/rtl/sssc_pkg.sv =====
// Shared types and constants for the slack calculator.
`timescale 1ns / 1ps
`default_nettype none
package sssc_pkg;

    localparam int MAX_TASKS = 16;
    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_CALC = 1'b1
    } cmd_t;

    typedef struct packed {
        logic        cmd;
        logic [3:0]  task_index;
        logic [31:0] period;
        logic [31:0] wcet;
        logic [31:0] rel_deadline;
        logic [31:0] wcrt;
        logic [31:0] current_tick;
        logic [31:0] wake_time;
        logic [31:0] completed_work;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] slack_value;
        logic [31:0]        slack_time;
        logic [31:0]        abs_deadline;
    } out_item_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RDUP,
        ST_SETUP,
        ST_PT_START,
        ST_WL_START,
        ST_WL_DIV,
        ST_WL_MUL,
        ST_WL_ACC,
        ST_EVAL,
        ST_NEXT_H,
        ST_HP_START,
        ST_HP_DIV,
        ST_HP_MUL,
        ST_WRITE,
        ST_OUT
    } state_t;

    // Datapath commands
    typedef struct packed {
        logic load;        // write task parameters
        logic rd_up;       // read higher-rank entry
        logic setup;       // deadline, corollaries
        logic pt_dl;       // next point is the deadline
        logic wl_start;    // start a workload sum at the point
        logic div_start;   // start ceiling division of point by period k
        logic wl_mul;      // multiply quotient by wcet
        logic wl_acc;      // accumulate product, advance k
        logic eval;        // compare slack at point
        logic h_start;     // start ceil(ival/p) for task h-1
        logic h_mul;       // form first multiple
        logic pt_adv;      // advance point by period
        logic h_dec;       // move to next higher task
        logic write;       // store results
    } dp_cmd_t;

    typedef struct packed {
        logic is_load;
        logic idx_ok;
        logic done_c2;
        logic div_busy;
        logic wl_last;     // k equals idx
        logic h_zero;      // no more higher tasks
        logic p_zero;      // period of task h-1 is zero
        logic pt_in;       // point below deadline
    } dp_sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sssc_div.sv =====
// Radix-2 restoring divider, 32 by 32 bits, ceiling quotient.
`timescale 1ns / 1ps
`default_nettype none
module sssc_div
    import sssc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             busy,
    output logic [32:0]      quot_ceil
);
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [31:0] q_reg, q_next;
    logic [32:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic [32:0] trial;

    always_comb begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        trial     = {r_reg[31:0], q_reg[31]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 6'd32;
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[30:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy      = busy_reg;
    // zero divisor gives zero
    assign quot_ceil = (d_reg == '0) ? 33'd0
                     : {1'b0, q_reg} + {32'd0, (r_reg != '0)};
endmodule
`default_nettype wire

// ===== hw/rtl/sssc_datapath.sv =====
// Task table, divider and slack arithmetic of the slack calculator.
`timescale 1ns / 1ps
`default_nettype none
module sssc_datapath
    import sssc_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire in_item_t  item,
    input  wire logic      item_take,
    input  wire dp_cmd_t   cmd,
    output dp_sts_t        sts,
    output out_item_t      result
);
    logic [31:0] per_mem   [MAX_TASKS];
    logic [31:0] wcet_mem  [MAX_TASKS];
    logic [31:0] dl_mem    [MAX_TASKS];
    logic [31:0] wcrt_mem  [MAX_TASKS];
    logic [31:0] absd_mem  [MAX_TASKS];
    logic [31:0] slk_mem   [MAX_TASKS];
    logic [31:0] slkt_mem  [MAX_TASKS];

    in_item_t    it_reg;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] up;
    logic [IDX_W-1:0] k_reg;
    logic [IDX_W:0]   h_reg;
    logic [IDX_W-1:0] hm1;
    logic [31:0] up_absd_reg, up_wcet_reg, up_slk_reg, up_slkt_reg;
    logic [31:0] my_dl_reg, my_wcet_reg, my_wcrt_reg;
    logic [31:0] di_reg, ival_reg, kmax_reg, tmax_reg;
    logic        c2_reg;
    logic [32:0] pt_reg;
    logic [31:0] t_reg;
    logic [31:0] w_reg;
    logic [31:0] prod_reg;
    logic [31:0] hp_reg;
    logic        div_busy;
    logic [32:0] div_q;
    logic        div_go;
    logic [31:0] div_a, div_b;
    logic [31:0] release_w, di_w, upend_w, ival_w, k2;
    logic [31:0] mul_full;

    assign idx = it_reg.task_index[IDX_W-1:0];
    assign up  = idx - 1'b1;
    assign hm1 = h_reg[IDX_W-1:0] - 1'b1;

    assign div_go = cmd.div_start || cmd.h_start;
    assign div_a  = cmd.h_start ? ival_reg : t_reg;
    assign div_b  = cmd.h_start ? per_mem[hm1] : per_mem[k_reg];

    sssc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_go),
        .dividend  (div_a),
        .divisor   (div_b),
        .busy      (div_busy),
        .quot_ceil (div_q)
    );

    assign release_w = (it_reg.current_tick != '0) ? it_reg.wake_time : 32'd0;
    assign di_w      = release_w + my_dl_reg;
    assign upend_w   = up_absd_reg + up_wcet_reg;
    assign ival_w    = release_w + my_dl_reg - my_wcrt_reg + my_wcet_reg;
    assign k2        = t_reg - it_reg.current_tick - w_reg + it_reg.completed_work;
    // the workload sum wraps at 32 bits, so keep the low half of the product
    assign mul_full  = div_q[31:0] * wcet_mem[k_reg];

    always_ff @(posedge aclk) begin
        if (item_take) begin
            it_reg <= item;
        end
        if (cmd.load) begin
            per_mem[idx]  <= it_reg.period;
            wcet_mem[idx] <= it_reg.wcet;
            dl_mem[idx]   <= it_reg.rel_deadline;
            wcrt_mem[idx] <= it_reg.wcrt;
        end
        if (cmd.rd_up) begin
            up_absd_reg <= absd_mem[up];
            up_wcet_reg <= wcet_mem[up];
            up_slk_reg  <= slk_mem[up];
            up_slkt_reg <= slkt_mem[up];
            my_dl_reg   <= dl_mem[idx];
            my_wcet_reg <= wcet_mem[idx];
            my_wcrt_reg <= wcrt_mem[idx];
        end
        if (cmd.setup) begin
            di_reg <= di_w;
            h_reg  <= {1'b0, idx};
            if (idx == '0) begin
                kmax_reg <= di_w - it_reg.current_tick - my_wcet_reg;
                tmax_reg <= di_w;
                c2_reg   <= 1'b1;
            end else if (upend_w >= di_w && di_w >= up_slkt_reg) begin
                kmax_reg <= up_slk_reg - my_wcet_reg;
                tmax_reg <= up_slkt_reg;
                c2_reg   <= 1'b1;
            end else if (upend_w >= ival_w && upend_w <= di_w) begin
                ival_reg <= upend_w;
                kmax_reg <= up_slk_reg - my_wcet_reg;
                tmax_reg <= up_slkt_reg;
                c2_reg   <= 1'b0;
            end else begin
                ival_reg <= ival_w;
                kmax_reg <= '0;
                tmax_reg <= 32'hFFFF_FFFF;
                c2_reg   <= 1'b0;
            end
        end
        if (cmd.pt_dl) begin
            t_reg <= di_reg;
        end
        if (cmd.wl_start) begin
            w_reg <= '0;
            k_reg <= '0;
        end
        if (cmd.wl_mul) begin
            prod_reg <= mul_full;
        end
        if (cmd.wl_acc) begin
            w_reg <= w_reg + prod_reg;
            k_reg <= k_reg + 1'b1;
        end
        if (cmd.eval) begin
            if ($signed(k2) > $signed(kmax_reg)) begin
                kmax_reg <= k2;
                tmax_reg <= t_reg;
            end else if (k2 == kmax_reg && t_reg < tmax_reg) begin
                tmax_reg <= t_reg;
            end
        end
        if (cmd.h_start) begin
            hp_reg <= per_mem[hm1];
        end
        if (cmd.h_mul) begin
            pt_reg <= div_q * {1'b0, hp_reg};
            t_reg  <= div_q[31:0] * hp_reg;
        end
        if (cmd.pt_adv) begin
            pt_reg <= pt_reg + {1'b0, hp_reg};
            t_reg  <= t_reg + hp_reg;
        end
        if (cmd.h_dec) begin
            h_reg <= h_reg - 1'b1;
        end
        if (cmd.write) begin
            absd_mem[idx] <= di_reg;
            slk_mem[idx]  <= kmax_reg;
            slkt_mem[idx] <= tmax_reg;
        end
    end

    assign sts.is_load  = (it_reg.cmd == CMD_LOAD);
    assign sts.idx_ok   = ({28'd0, it_reg.task_index} < 32'(MAX_TASKS));
    assign sts.done_c2  = c2_reg;
    assign sts.div_busy = div_busy;
    assign sts.wl_last  = (k_reg == idx);
    assign sts.h_zero   = (h_reg == '0);
    assign sts.p_zero   = (per_mem[hm1] == '0);
    assign sts.pt_in    = (pt_reg < {1'b0, di_reg});

    assign result.slack_value  = kmax_reg;
    assign result.slack_time   = tmax_reg;
    assign result.abs_deadline = di_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/sssc_ctrl.sv =====
// Sequencer of the slack calculator.
`timescale 1ns / 1ps
`default_nettype none
module sssc_ctrl
    import sssc_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    output logic         m_valid,
    input  wire logic    m_ready,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd
);
    state_t state_reg, state_next;
    logic   evalh_reg, evalh_next;   // set while scanning multiples

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            evalh_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            evalh_reg <= evalh_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        evalh_next = evalh_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (!sts.idx_ok) begin
                    state_next = ST_IDLE;
                end else if (sts.is_load) begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_RDUP;
                end
            end
            ST_RDUP: begin
                cmd.rd_up  = 1'b1;
                state_next = ST_SETUP;
            end
            ST_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = ST_PT_START;
            end
            ST_PT_START: begin
                if (sts.done_c2) begin
                    state_next = ST_WRITE;
                end else begin
                    cmd.pt_dl  = 1'b1;
                    evalh_next = 1'b0;
                    state_next = ST_WL_START;
                end
            end
            ST_WL_START: begin
                cmd.wl_start = 1'b1;
                state_next   = ST_WL_DIV;
            end
            ST_WL_DIV: begin
                cmd.div_start = 1'b1;
                state_next    = ST_WL_MUL;
            end
            ST_WL_MUL: begin
                if (!sts.div_busy) begin
                    cmd.wl_mul = 1'b1;
                    state_next = ST_WL_ACC;
                end
            end
            ST_WL_ACC: begin
                cmd.wl_acc = 1'b1;
                state_next = sts.wl_last ? ST_EVAL : ST_WL_DIV;
            end
            ST_EVAL: begin
                cmd.eval = 1'b1;
                if (evalh_reg) begin
                    cmd.pt_adv = 1'b1;
                    state_next = ST_HP_MUL;
                end else begin
                    state_next = ST_NEXT_H;
                end
            end
            ST_NEXT_H: begin
                if (sts.h_zero) begin
                    state_next = ST_WRITE;
                end else if (sts.p_zero) begin
                    cmd.h_dec = 1'b1;
                end else begin
                    cmd.h_start = 1'b1;
                    state_next  = ST_HP_START;
                end
            end
            ST_HP_START: begin
                state_next = ST_HP_DIV;
            end
            ST_HP_DIV: begin
                if (!sts.div_busy) begin
                    cmd.h_mul  = 1'b1;
                    evalh_next = 1'b1;
                    state_next = ST_HP_MUL;
                end
            end
            ST_HP_MUL: begin
                // point ready: scan it or drop to next task
                if (sts.pt_in) begin
                    state_next = ST_WL_START;
                end else begin
                    cmd.h_dec  = 1'b1;
                    evalh_next = 1'b0;
                    state_next = ST_NEXT_H;
                end
            end
            ST_WRITE: begin
                cmd.write  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("input and output both open");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");
    a_write_then_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.write |=> m_valid) else $error("write without result");
endmodule
`default_nettype wire

// ===== hw/rtl/slack_stealing_slack_calc.sv =====
// Top level: slack calculator for fixed-priority slack stealing.
// Load: a transfer writes the task table. Calculate: rank 0 and Corollary 2
// cases go from setup straight to the write and result states; otherwise each
// scan point needs a workload sum over tasks 0..rank, a division by the shared
// 32-step divider per task, plus a division per higher task scanned. One item at
// a time. aresetn is synchronous, active low; the task table is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module slack_stealing_slack_calc
    import sssc_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);
    dp_cmd_t cmd;
    dp_sts_t sts;

    sssc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    sssc_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item      (s_data),
        .item_take (s_valid && s_ready),
        .cmd       (cmd),
        .sts       (sts),
        .result    (m_data)
    );
endmodule
`default_nettype wire
